// ----- hdl/slbs_pkg.sv -----
package slbs_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int POS_BITS    = 16;
  localparam int IDX_BITS    = $clog2(STACK_DEPTH);
  localparam int CNT_BITS    = $clog2(STACK_DEPTH + 1);
  localparam int FIFO_DEPTH  = 2;

  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_CARET   = 8'h5e;
  localparam logic [7:0] CH_NL      = 8'h0a;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_SQUOTE  = 8'h27;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LBRACK  = 8'h5b;
  localparam logic [7:0] CH_RBRACK  = 8'h5d;
  localparam logic [7:0] CH_LBRACE  = 8'h7b;
  localparam logic [7:0] CH_RBRACE  = 8'h7d;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_PAREN = 2'd1;
  localparam logic [1:0] KIND_BRACK = 2'd2;
  localparam logic [1:0] KIND_BRACE = 2'd3;

  localparam logic [1:0] QUOTE_NONE   = 2'd0;
  localparam logic [1:0] QUOTE_SINGLE = 2'd1;
  localparam logic [1:0] QUOTE_DOUBLE = 2'd2;

  localparam logic [1:0] FLAVOR_PLAIN = 2'd0;
  localparam logic [1:0] FLAVOR_NAME  = 2'd1;
  localparam logic [1:0] FLAVOR_PATH  = 2'd2;

  localparam logic [2:0] LEX_CODE    = 3'd0;
  localparam logic [2:0] LEX_COMMENT = 3'd1;
  localparam logic [2:0] LEX_STRING  = 3'd2;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_OPEN    = 3'd1,
    ACT_CLOSE   = 3'd2,
    ACT_COMMA   = 3'd3,
    ACT_NEWLINE = 3'd4
  } act_t;

  typedef struct packed {
    logic                clear;
    logic                is_code;
    act_t                act;
    logic [1:0]          kind;
    logic [POS_BITS-1:0] pos;
    logic [2:0]          lex_state;
    logic [1:0]          quote;
  } op_t;

endpackage

// ----- hdl/script_lexical_bracket_scanner_core.sv -----
// The scanner takes one source byte per item with its two-byte lookahead and
// returns one result item per byte, in order. It sustains one item per clock
// cycle while results are popped and the queue is not full. The front
// classifies the byte and tracks comments and strings, a two-entry queue holds
// the classified items, and the back updates the bracket stack, searching all
// stack entries at once for a closer, before the result is registered.
module script_lexical_bracket_scanner_core
  import slbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic        in_first_byte,
  input  logic [7:0]  in_text_byte,
  input  logic [7:0]  in_next_byte,
  input  logic [7:0]  in_after_next_byte,
  input  logic        in_lookahead_ok,
  output logic        empty,
  input  logic        pop,
  output logic        out_byte_is_code,
  output logic [2:0]  out_lexical_state,
  output logic [1:0]  out_open_quote,
  output logic [5:0]  out_nesting_depth,
  output logic [1:0]  out_top_kind,
  output logic [15:0] out_top_offset,
  output logic [7:0]  out_top_comma_count,
  output logic [15:0] out_top_last_comma,
  output logic [15:0] out_statement_begin,
  output logic        out_stack_overflow
);

  op_t                 f_op, q_op;
  logic                take_in, q_empty, q_full, take_q;
  logic                out_valid_r;
  logic [CNT_BITS-1:0] b_depth;
  logic [1:0]          b_kind;
  logic [POS_BITS-1:0] b_off, b_last, b_mark;
  logic [7:0]          b_commas;
  logic                b_ovf;

  assign full    = q_full;
  assign take_in = push && !q_full;
  assign empty   = !out_valid_r;
  assign take_q  = !q_empty && (!out_valid_r || pop);

  slbs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .take            (take_in),
    .first_byte      (in_first_byte),
    .text_byte       (in_text_byte),
    .next_byte       (in_next_byte),
    .after_next_byte (in_after_next_byte),
    .lookahead_ok    (in_lookahead_ok),
    .op              (f_op)
  );

  slbs_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (take_in),
    .wr_op    (f_op),
    .rd_en    (take_q),
    .rd_op    (q_op),
    .is_full  (q_full),
    .is_empty (q_empty)
  );

  slbs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take_q),
    .op         (q_op),
    .depth      (b_depth),
    .top_kind   (b_kind),
    .top_offset (b_off),
    .top_commas (b_commas),
    .top_last   (b_last),
    .mark       (b_mark),
    .overflow   (b_ovf)
  );

  always_ff @(posedge clk) begin
    if (take_q) begin
      out_byte_is_code    <= q_op.is_code;
      out_lexical_state   <= q_op.lex_state;
      out_open_quote      <= q_op.quote;
      out_nesting_depth   <= 6'(b_depth);
      out_top_kind        <= b_kind;
      out_top_offset      <= 16'(b_off);
      out_top_comma_count <= b_commas;
      out_top_last_comma  <= 16'(b_last);
      out_statement_begin <= 16'(b_mark);
      out_stack_overflow  <= b_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take_q) begin
      out_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_code_state: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_byte_is_code) |-> (out_lexical_state == LEX_CODE))
    else $error("code byte reported outside code state");

  a_quote_state: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_open_quote == QUOTE_NONE) ==
                (out_lexical_state == LEX_CODE || out_lexical_state == LEX_COMMENT)))
    else $error("open quote disagrees with lexical state");

  a_top_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> ((out_top_kind == KIND_NONE) == (out_nesting_depth == 6'd0)))
    else $error("top kind disagrees with nesting depth");
`endif

endmodule

// ----- hdl/slbs_front.sv -----
module slbs_front
  import slbs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic       first_byte,
  input  logic [7:0] text_byte,
  input  logic [7:0] next_byte,
  input  logic [7:0] after_next_byte,
  input  logic       lookahead_ok,
  output op_t        op
);

  logic [POS_BITS-1:0] pos_r, pos_nxt;
  logic                comment_r, comment_nxt;
  logic [1:0]          quote_r, quote_nxt;
  logic                triple_r, triple_nxt;
  logic                escape_r, escape_nxt;
  logic [1:0]          flavor_r, flavor_nxt;
  logic [7:0]          prev_r, prev_nxt;
  logic [1:0]          skip_r, skip_nxt;

  always_comb begin
    logic [POS_BITS-1:0] pos;
    logic                com;
    logic [1:0]          q;
    logic                tri_q;
    logic                esc;
    logic [1:0]          flv;
    logic [7:0]          prv;
    logic [1:0]          skp;
    logic [7:0]          qchar;
    pos   = first_byte ? '0 : pos_r;
    com   = first_byte ? 1'b0 : comment_r;
    q     = first_byte ? QUOTE_NONE : quote_r;
    tri_q = first_byte ? 1'b0 : triple_r;
    esc   = first_byte ? 1'b0 : escape_r;
    flv   = first_byte ? FLAVOR_PLAIN : flavor_r;
    prv   = first_byte ? 8'h00 : prev_r;
    skp   = first_byte ? 2'd0 : skip_r;
    qchar = (q == QUOTE_SINGLE) ? CH_SQUOTE : CH_DQUOTE;

    comment_nxt = com;
    quote_nxt   = q;
    triple_nxt  = tri_q;
    escape_nxt  = esc;
    flavor_nxt  = flv;
    skip_nxt    = skp;
    op          = '0;
    op.clear    = first_byte;
    op.pos      = pos;
    op.act      = ACT_NONE;
    op.kind     = KIND_NONE;

    if (skp != 2'd0) begin
      skip_nxt = skp - 2'd1;
    end else if (com) begin
      if (text_byte == CH_NL) begin
        comment_nxt = 1'b0;
        op.act      = ACT_NEWLINE;
      end
    end else if (q != QUOTE_NONE) begin
      if (tri_q && text_byte == qchar && lookahead_ok && next_byte == qchar &&
          after_next_byte == qchar) begin
        skip_nxt   = 2'd2;
        quote_nxt  = QUOTE_NONE;
        triple_nxt = 1'b0;
        escape_nxt = 1'b0;
      end else if (esc) begin
        escape_nxt = 1'b0;
      end else if (text_byte == CH_BSLASH) begin
        escape_nxt = 1'b1;
      end else if (!tri_q && text_byte == qchar) begin
        quote_nxt = QUOTE_NONE;
      end
    end else if (text_byte == CH_HASH) begin
      comment_nxt = 1'b1;
    end else if (text_byte == CH_SQUOTE || text_byte == CH_DQUOTE) begin
      quote_nxt  = (text_byte == CH_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
      escape_nxt = 1'b0;
      flavor_nxt = (prv == CH_AMP) ? FLAVOR_NAME :
                   (prv == CH_CARET) ? FLAVOR_PATH : FLAVOR_PLAIN;
      if (lookahead_ok && next_byte == text_byte && after_next_byte == text_byte) begin
        triple_nxt = 1'b1;
        skip_nxt   = 2'd2;
      end
    end else begin
      op.is_code = 1'b1;
      case (text_byte)
        CH_LPAREN: begin op.act = ACT_OPEN;  op.kind = KIND_PAREN; end
        CH_LBRACK: begin op.act = ACT_OPEN;  op.kind = KIND_BRACK; end
        CH_LBRACE: begin op.act = ACT_OPEN;  op.kind = KIND_BRACE; end
        CH_RPAREN: begin op.act = ACT_CLOSE; op.kind = KIND_PAREN; end
        CH_RBRACK: begin op.act = ACT_CLOSE; op.kind = KIND_BRACK; end
        CH_RBRACE: begin op.act = ACT_CLOSE; op.kind = KIND_BRACE; end
        CH_COMMA:  op.act = ACT_COMMA;
        CH_NL:     op.act = ACT_NEWLINE;
        default:   op.act = ACT_NONE;
      endcase
    end

    prev_nxt = text_byte;
    pos_nxt  = (pos == POS_MAX) ? POS_MAX : pos + 1'b1;

    op.quote     = quote_nxt;
    op.lex_state = comment_nxt ? LEX_COMMENT :
                   (quote_nxt != QUOTE_NONE) ? (LEX_STRING + {1'b0, flavor_nxt}) : LEX_CODE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      comment_r <= 1'b0;
      quote_r   <= QUOTE_NONE;
      triple_r  <= 1'b0;
      escape_r  <= 1'b0;
      flavor_r  <= FLAVOR_PLAIN;
      prev_r    <= 8'h00;
      skip_r    <= 2'd0;
    end else if (take) begin
      pos_r     <= pos_nxt;
      comment_r <= comment_nxt;
      quote_r   <= quote_nxt;
      triple_r  <= triple_nxt;
      escape_r  <= escape_nxt;
      flavor_r  <= flavor_nxt;
      prev_r    <= prev_nxt;
      skip_r    <= skip_nxt;
    end
  end

endmodule

// ----- hdl/slbs_fifo.sv -----
module slbs_fifo
  import slbs_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  op_t  wr_op,
  input  logic rd_en,
  output op_t  rd_op,
  output logic is_full,
  output logic is_empty
);

  localparam int PTR_BITS = $clog2(FIFO_DEPTH);

  op_t                 mem_r [FIFO_DEPTH];
  logic [PTR_BITS-1:0] wptr_r, rptr_r;
  logic [PTR_BITS:0]   cnt_r;

  assign is_full  = (cnt_r == (PTR_BITS+1)'(FIFO_DEPTH));
  assign is_empty = (cnt_r == '0);
  assign rd_op    = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wptr_r] <= wr_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (wr_en) begin
        wptr_r <= (wptr_r == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (rd_en) begin
        rptr_r <= (rptr_r == PTR_BITS'(FIFO_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hdl/slbs_back.sv -----
module slbs_back
  import slbs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                take,
  input  op_t                 op,
  output logic [CNT_BITS-1:0] depth,
  output logic [1:0]          top_kind,
  output logic [POS_BITS-1:0] top_offset,
  output logic [7:0]          top_commas,
  output logic [POS_BITS-1:0] top_last,
  output logic [POS_BITS-1:0] mark,
  output logic                overflow
);

  logic [1:0]          kind_r  [STACK_DEPTH];
  logic [POS_BITS-1:0] off_r   [STACK_DEPTH];
  logic [7:0]          com_r   [STACK_DEPTH];
  logic [POS_BITS-1:0] last_r  [STACK_DEPTH];
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [POS_BITS-1:0] mark_r, mark_nxt;
  logic                ovf_r, ovf_nxt;

  logic [CNT_BITS-1:0] cnt_eff;
  logic [IDX_BITS-1:0] top_idx;
  logic                do_push, do_comma;
  logic [7:0]          com_inc;
  logic                hit;
  logic [IDX_BITS-1:0] hit_idx;
  logic [IDX_BITS-1:0] rd_idx;

  assign cnt_eff  = op.clear ? '0 : cnt_r;
  assign top_idx  = IDX_BITS'(cnt_eff - 1'b1);
  assign do_push  = (op.act == ACT_OPEN) && (cnt_eff < CNT_BITS'(STACK_DEPTH));
  assign do_comma = (op.act == ACT_COMMA) && (cnt_eff != '0) &&
                    (kind_r[top_idx] == KIND_PAREN);
  assign com_inc  = (com_r[top_idx] == 8'hff) ? 8'hff : com_r[top_idx] + 8'd1;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (CNT_BITS'(i) < cnt_eff && kind_r[i] == op.kind) begin
        hit     = 1'b1;
        hit_idx = IDX_BITS'(i);
      end
    end
  end

  always_comb begin
    cnt_nxt  = cnt_eff;
    mark_nxt = op.clear ? '0 : mark_r;
    ovf_nxt  = op.clear ? 1'b0 : ovf_r;
    case (op.act)
      ACT_OPEN: begin
        if (do_push) begin
          cnt_nxt = cnt_eff + 1'b1;
        end else begin
          ovf_nxt = 1'b1;
        end
      end
      ACT_CLOSE: begin
        if (hit) begin
          cnt_nxt = CNT_BITS'(hit_idx);
        end
      end
      ACT_NEWLINE: begin
        if (cnt_eff == '0) begin
          mark_nxt = (op.pos == POS_MAX) ? POS_MAX : op.pos + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign rd_idx = IDX_BITS'(cnt_nxt - 1'b1);

  always_comb begin
    depth = cnt_nxt;
    mark  = mark_nxt;
    overflow = ovf_nxt;
    if (cnt_nxt == '0) begin
      top_kind   = KIND_NONE;
      top_offset = '0;
      top_commas = 8'd0;
      top_last   = '0;
    end else if (do_push) begin
      top_kind   = op.kind;
      top_offset = op.pos;
      top_commas = 8'd0;
      top_last   = '0;
    end else if (do_comma) begin
      top_kind   = kind_r[rd_idx];
      top_offset = off_r[rd_idx];
      top_commas = com_inc;
      top_last   = op.pos;
    end else begin
      top_kind   = kind_r[rd_idx];
      top_offset = off_r[rd_idx];
      top_commas = com_r[rd_idx];
      top_last   = (com_r[rd_idx] != 8'd0) ? last_r[rd_idx] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && do_push) begin
      kind_r[IDX_BITS'(cnt_eff)] <= op.kind;
      off_r[IDX_BITS'(cnt_eff)]  <= op.pos;
      com_r[IDX_BITS'(cnt_eff)]  <= 8'd0;
      last_r[IDX_BITS'(cnt_eff)] <= '0;
    end else if (take && do_comma) begin
      com_r[top_idx]  <= com_inc;
      last_r[top_idx] <= op.pos;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      mark_r <= '0;
      ovf_r  <= 1'b0;
    end else if (take) begin
      cnt_r  <= cnt_nxt;
      mark_r <= mark_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

endmodule

// ----- tb/lexical_scan_checker.sv -----
module lexical_scan_checker
  import slbs_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  logic        full,
  input  logic        in_first_byte,
  input  logic [7:0]  in_text_byte,
  input  logic [7:0]  in_next_byte,
  input  logic [7:0]  in_after_next_byte,
  input  logic        in_lookahead_ok,
  input  logic        empty,
  input  logic        pop,
  input  logic        out_byte_is_code,
  input  logic [2:0]  out_lexical_state,
  input  logic [1:0]  out_open_quote,
  input  logic [5:0]  out_nesting_depth,
  input  logic [1:0]  out_top_kind,
  input  logic [15:0] out_top_offset,
  input  logic [7:0]  out_top_comma_count,
  input  logic [15:0] out_top_last_comma,
  input  logic [15:0] out_statement_begin,
  input  logic        out_stack_overflow,
  output int          fail_count,
  output int          pending_count,
  output int          result_count
);

  typedef struct packed {
    logic        is_code;
    logic [2:0]  lex;
    logic [1:0]  quote;
    logic [5:0]  depth;
    logic [1:0]  kind;
    logic [15:0] offset;
    logic [7:0]  commas;
    logic [15:0] last_comma;
    logic [15:0] stmt;
    logic        overflow;
  } scan_result_t;

  scan_result_t expected_scans[$];

  logic [15:0] position;
  logic        comment_open;
  logic [1:0]  quote_kind;
  logic        triple_open;
  logic        escape_open;
  logic [1:0]  flavor;
  logic [7:0]  prior_byte;
  logic [1:0]  skip_left;
  logic [1:0]  stk_kind [STACK_DEPTH];
  logic [15:0] stk_offset [STACK_DEPTH];
  logic [7:0]  stk_commas [STACK_DEPTH];
  logic [15:0] stk_last [STACK_DEPTH];
  int          depth;
  logic [15:0] stmt_mark;
  logic        overflow_flag;

  function automatic logic [15:0] bump(logic [15:0] p);
    return p == POS_MAX ? p : p + 16'd1;
  endfunction

  task automatic clear_scan();
    position = '0; comment_open = 0; quote_kind = QUOTE_NONE; triple_open = 0;
    escape_open = 0; flavor = FLAVOR_PLAIN; prior_byte = '0; skip_left = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      stk_kind[i] = KIND_NONE; stk_offset[i] = '0; stk_commas[i] = '0; stk_last[i] = '0;
    end
    depth = 0; stmt_mark = '0; overflow_flag = 0;
  endtask

  task automatic code_byte(logic [7:0] c, logic [15:0] p);
    logic [1:0] opener;
    logic [1:0] closer;
    opener = c == CH_LPAREN ? KIND_PAREN : c == CH_LBRACK ? KIND_BRACK :
             c == CH_LBRACE ? KIND_BRACE : KIND_NONE;
    closer = c == CH_RPAREN ? KIND_PAREN : c == CH_RBRACK ? KIND_BRACK :
             c == CH_RBRACE ? KIND_BRACE : KIND_NONE;
    if (opener != KIND_NONE) begin
      if (depth < STACK_DEPTH) begin
        stk_kind[depth] = opener; stk_offset[depth] = p;
        stk_commas[depth] = '0; stk_last[depth] = '0;
        depth++;
      end else begin
        overflow_flag = 1;
      end
    end else if (closer != KIND_NONE) begin
      for (int i = depth; i > 0; i--) begin
        if (stk_kind[i-1] == closer) begin
          depth = i - 1;
          break;
        end
      end
    end else if (c == CH_COMMA && depth > 0 && stk_kind[depth-1] == KIND_PAREN) begin
      if (stk_commas[depth-1] != 8'hFF) stk_commas[depth-1]++;
      stk_last[depth-1] = p;
    end else if (c == CH_NL && depth == 0) begin
      stmt_mark = bump(p);
    end
  endtask

  task automatic predict_scan(logic first, logic [7:0] c, logic [7:0] n1, logic [7:0] n2,
                              logic look);
    scan_result_t r;
    logic [15:0] p;
    logic [7:0] qc;
    logic code;
    code = 0;
    if (first) clear_scan();
    p = position;
    qc = quote_kind == QUOTE_SINGLE ? CH_SQUOTE : CH_DQUOTE;
    if (skip_left != 0) begin
      skip_left--;
    end else if (comment_open) begin
      if (c == CH_NL) begin
        comment_open = 0;
        if (depth == 0) stmt_mark = bump(p);
      end
    end else if (quote_kind != QUOTE_NONE) begin
      if (triple_open && c == qc && look && n1 == qc && n2 == qc) begin
        skip_left = 2; quote_kind = QUOTE_NONE; triple_open = 0; escape_open = 0;
      end else if (escape_open) begin
        escape_open = 0;
      end else if (c == CH_BSLASH) begin
        escape_open = 1;
      end else if (!triple_open && c == qc) begin
        quote_kind = QUOTE_NONE;
      end
    end else if (c == CH_HASH) begin
      comment_open = 1;
    end else if (c == CH_SQUOTE || c == CH_DQUOTE) begin
      quote_kind = c == CH_SQUOTE ? QUOTE_SINGLE : QUOTE_DOUBLE;
      escape_open = 0;
      flavor = prior_byte == CH_AMP ? FLAVOR_NAME :
               prior_byte == CH_CARET ? FLAVOR_PATH : FLAVOR_PLAIN;
      if (look && n1 == c && n2 == c) begin
        triple_open = 1; skip_left = 2;
      end
    end else begin
      code = 1;
      code_byte(c, p);
    end
    prior_byte = c;
    position = bump(p);

    r.is_code = code;
    r.lex = comment_open ? LEX_COMMENT :
            quote_kind != QUOTE_NONE ? LEX_STRING + 3'(flavor) : LEX_CODE;
    r.quote = quote_kind;
    r.depth = 6'(depth);
    if (depth > 0) begin
      r.kind = stk_kind[depth-1]; r.offset = stk_offset[depth-1];
      r.commas = stk_commas[depth-1];
      r.last_comma = stk_commas[depth-1] != 0 ? stk_last[depth-1] : '0;
    end else begin
      r.kind = KIND_NONE; r.offset = '0; r.commas = '0; r.last_comma = '0;
    end
    r.stmt = stmt_mark;
    r.overflow = overflow_flag;
    expected_scans = {expected_scans, r};
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    scan_result_t e;
    if (!rst_n) begin
      clear_scan();
      expected_scans.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      if (pop && !empty) begin
        result_count++;
        if (expected_scans.size() == 0) begin
          $error("result item with no expectation waiting");
          fail_count++;
        end else begin
          e = expected_scans.pop_front();
          check_field("byte_is_code", 16'(e.is_code), 16'(out_byte_is_code));
          check_field("lexical_state", 16'(e.lex), 16'(out_lexical_state));
          check_field("open_quote", 16'(e.quote), 16'(out_open_quote));
          check_field("nesting_depth", 16'(e.depth), 16'(out_nesting_depth));
          check_field("top_kind", 16'(e.kind), 16'(out_top_kind));
          check_field("top_offset", e.offset, out_top_offset);
          check_field("top_comma_count", 16'(e.commas), 16'(out_top_comma_count));
          check_field("top_last_comma", e.last_comma, out_top_last_comma);
          check_field("statement_begin", e.stmt, out_statement_begin);
          check_field("stack_overflow", 16'(e.overflow), 16'(out_stack_overflow));
        end
      end
      if (push && !full)
        predict_scan(in_first_byte, in_text_byte, in_next_byte, in_after_next_byte,
                     in_lookahead_ok);
    end
    pending_count = expected_scans.size();
  end

endmodule

// ----- tb/tb.sv -----
module tb;
  import slbs_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        push = 0;
  logic        full;
  logic        in_first_byte = 0;
  logic [7:0]  in_text_byte = '0;
  logic [7:0]  in_next_byte = '0;
  logic [7:0]  in_after_next_byte = '0;
  logic        in_lookahead_ok = 0;
  logic        empty;
  logic        pop = 0;
  logic        out_byte_is_code;
  logic [2:0]  out_lexical_state;
  logic [1:0]  out_open_quote;
  logic [5:0]  out_nesting_depth;
  logic [1:0]  out_top_kind;
  logic [15:0] out_top_offset;
  logic [7:0]  out_top_comma_count;
  logic [15:0] out_top_last_comma;
  logic [15:0] out_statement_begin;
  logic        out_stack_overflow;
  int          fail_count;
  int          pending_count;
  int          result_count;

  int          send_idle_pct = 0;
  int          pop_stall_pct = 0;
  int          hold_request = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  logic [7:0]  text_bytes[$];

  always #5 clk = ~clk;

  script_lexical_bracket_scanner_core dut (.*);

  lexical_scan_checker checker_i (.*);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 2000000) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (hold_request > 0) begin
      pop <= 0;
      hold_request--;
    end else begin
      pop <= $urandom_range(99) >= pop_stall_pct;
    end
  end

  task automatic send_byte(logic first, logic [7:0] c, logic [7:0] n1, logic [7:0] n2,
                           logic look);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 0;
      @(negedge clk);
    end
    push <= 1;
    in_first_byte <= first;
    in_text_byte <= c;
    in_next_byte <= n1;
    in_after_next_byte <= n2;
    in_lookahead_ok <= look;
    do @(posedge clk); while (full);
    items_sent++;
  endtask

  task automatic send_text();
    int n;
    n = text_bytes.size();
    for (int i = 0; i < n; i++) begin
      send_byte(i == 0, text_bytes[i],
                i + 1 < n ? text_bytes[i+1] : 8'($urandom),
                i + 2 < n ? text_bytes[i+2] : 8'($urandom), i + 2 < n);
    end
  endtask

  task automatic add_byte(logic [7:0] b);
    text_bytes = {text_bytes, b};
  endtask

  task automatic add_chars(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic build_text(int len);
    text_bytes.delete();
    while (text_bytes.size() < len) begin
      case ($urandom_range(0, 21))
        0, 1:   add_byte(CH_LPAREN);
        2:      add_byte(CH_RPAREN);
        3:      add_byte(CH_LBRACK);
        4:      add_byte(CH_RBRACK);
        5:      add_byte(CH_LBRACE);
        6:      add_byte(CH_RBRACE);
        7, 8:   add_byte(CH_COMMA);
        9:      add_byte(CH_NL);
        10:     add_byte(CH_HASH);
        11:     add_byte(CH_SQUOTE);
        12:     add_byte(CH_DQUOTE);
        13:     add_byte(CH_BSLASH);
        14:     add_byte(CH_AMP);
        15:     add_byte(CH_CARET);
        16:     add_chars("'''");
        17:     add_chars("\"\"\"");
        18:     add_byte(8'($urandom));
        default: add_byte(8'($urandom_range(8'h61, 8'h7a)));
      endcase
    end
  endtask

  task automatic random_phase(int count);
    int start;
    start = items_sent;
    while (items_sent - start < count) begin
      if ($urandom_range(9) == 0) begin
        send_byte($urandom_range(1), 8'($urandom), 8'($urandom), 8'($urandom),
                  $urandom_range(1));
      end else begin
        build_text($urandom_range(1, 60));
        send_text();
      end
    end
  endtask

  task automatic drain();
    send_idle_pct = 0;
    @(negedge clk);
    push <= 0;
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    text_bytes.delete();
    add_chars(")]}(a,b,[x],{y})\n&'s\\'t'^\"n\"'''a\\'''\"\"\"q\"\"\" #c\n");
    add_chars("''\"");
    send_text();
    text_bytes.delete();
    repeat (34) add_byte(CH_LBRACE);
    add_chars("(,,)]\n");
    send_text();
    send_byte(1, 8'hFF, 8'hFF, 8'hFF, 0);
    send_byte(0, CH_SQUOTE, CH_SQUOTE, CH_SQUOTE, 0);
    send_byte(0, 8'h00, 8'h00, 8'h00, 1);
    drain();

    text_bytes.delete();
    add_byte(CH_LPAREN);
    repeat (300) add_byte(CH_COMMA);
    add_byte(CH_RPAREN);
    while (text_bytes.size() < 320)
      add_byte($urandom_range(3) == 0 ? CH_NL : 8'h61);
    send_text();
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = phase == 1 || phase == 3 ? (phase == 1 ? 79 : 11) : 0;
      pop_stall_pct = phase == 2 || phase == 3 ? (phase == 2 ? 79 : 11) : 0;
      random_phase(280);
      hold_request = 300;
      random_phase(30);
      drain();
      send_idle_pct = 0;
      pop_stall_pct = 0;
      random_phase(40);
    end
    drain();
    repeat (10) @(posedge clk);

    $display("Scanned %0d bytes in directed, saturation and random texts; %0d results checked.",
             items_sent, result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- script_lexical_bracket_scanner_core.f -----
hdl/slbs_pkg.sv
hdl/slbs_front.sv
hdl/slbs_fifo.sv
hdl/slbs_back.sv
hdl/script_lexical_bracket_scanner_core.sv
tb/lexical_scan_checker.sv
tb/tb.sv
